@@ rtl/core/pwm_motor_led_driver_debounced_assert.svh @@
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef PWM_MOTOR_LED_DRIVER_DEBOUNCED_ASSERT_SVH
`define PWM_MOTOR_LED_DRIVER_DEBOUNCED_ASSERT_SVH

// Same-cycle implication.
`define PMLD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PMLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pmld_pkg.sv @@
package pmld_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned LOCK_W  = 8;
  localparam int unsigned IDX_W   = 3;

  // register indexes (byte address 4*i)
  localparam logic REG_RED_DUTY      = 1'b0;
  localparam logic REG_LOCKOUT_TICKS = 1'b1;

  localparam logic [DUTY_W-1:0] RED_DUTY_RESET = 8'd0;
  localparam logic [LOCK_W-1:0] LOCKOUT_RESET  = 8'd100;

  // step runs 0..254, then wraps
  localparam logic [STEP_W-1:0] STEP_LAST  = 8'd254;
  localparam logic [IDX_W-1:0]  LEVEL_LAST = 3'd5;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_EDGE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [DUTY_W-1:0] red_duty;
    logic [LOCK_W-1:0] lockout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_count;
    logic [LOCK_W-1:0] lockout_count;
    logic [IDX_W-1:0]  level_index;
    logic [DUTY_W-1:0] motor_level;
    logic              red_latch;
    logic              motor_latch;
    logic              white_latch;
  } state_t;

  function automatic logic [DUTY_W-1:0] level_value(input logic [IDX_W-1:0] idx);
    logic [DUTY_W-1:0] val;
    case (idx)
      3'd1:    val = 8'd10;
      3'd2:    val = 8'd50;
      3'd3:    val = 8'd100;
      3'd4:    val = 8'd200;
      3'd5:    val = 8'd255;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/core/pmld_in_if.sv @@
interface pmld_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic button_level;

  modport source (output valid, output kind, output button_level, input ready);
  modport sink (input valid, input kind, input button_level, output ready);
endinterface

@@ rtl/core/pmld_out_if.sv @@
interface pmld_out_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       white_on;
  logic       motor_on;
  logic [7:0] motor_duty;

  modport source (
    output valid, output red_on, output white_on, output motor_on, output motor_duty,
    input ready
  );
  modport sink (
    input valid, input red_on, input white_on, input motor_on, input motor_duty,
    output ready
  );
endinterface

@@ rtl/core/pwm_motor_led_driver_debounced.sv @@
// Three-output PWM driver (red LED, white LED, motor) with a debounced button that
// steps the motor duty through 10, 50, 100, 200, 255 and off. Each input beat is a
// timer tick or a button rising edge and yields exactly one result beat carrying
// the output levels and current motor duty. One beat is taken every clock cycle
// unless result ready holds it off; each beat passes the input register and the
// result register, with the whole state update done between them. A waiting
// result holds the input off only once the input register is full as well; input
// ready then follows result ready in the same cycle. Registers via APB: red_duty
// at 0x0, lockout_ticks at 0x4; write only while idle.
module pwm_motor_led_driver_debounced (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmld_pkg::PADDR_W-1:0]  paddr,
  input  logic [pmld_pkg::DATA_W-1:0]   pwdata,
  output logic [pmld_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  pmld_in_if.sink                       in_i,
  pmld_out_if.source                    out_o
);
  import pmld_pkg::*;

  cfg_t cfg;

  pmld_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pmld_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

@@ rtl/core/pmld_cfg.sv @@
module pmld_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmld_pkg::PADDR_W-1:0]  paddr,
  input  logic [pmld_pkg::DATA_W-1:0]   pwdata,
  output logic [pmld_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output pmld_pkg::cfg_t                cfg_o
);
  import pmld_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  // low address bits are ignored, one register per word
  assign reg_idx = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_RED_DUTY:      cfg_d.red_duty      = pwdata[DUTY_W-1:0];
        REG_LOCKOUT_TICKS: cfg_d.lockout_ticks = pwdata[LOCK_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RED_DUTY:      prdata = {{(DATA_W-DUTY_W){1'b0}}, cfg_q.red_duty};
      REG_LOCKOUT_TICKS: prdata = {{(DATA_W-LOCK_W){1'b0}}, cfg_q.lockout_ticks};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_duty      <= RED_DUTY_RESET;
      cfg_q.lockout_ticks <= LOCKOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/pmld_core.sv @@
`include "pwm_motor_led_driver_debounced_assert.svh"

module pmld_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pmld_pkg::cfg_t    cfg_i,
  pmld_in_if.sink           in_i,
  pmld_out_if.source        out_o
);
  import pmld_pkg::*;

  // input register
  logic  in_vld_q;
  kind_e in_kind_q;
  logic  in_btn_q;

  // working state
  state_t st_q, st_d;

  // result register
  logic              out_vld_q;
  logic              red_q, white_q, motor_q;
  logic [DUTY_W-1:0] duty_q;

  logic fire;
  logic in_take;

  assign fire    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_take = in_i.valid && in_i.ready;
  assign in_i.ready = !in_vld_q || fire;

  always_comb begin
    logic [STEP_W-1:0] step_n;
    logic [IDX_W-1:0]  idx_n;
    st_d   = st_q;
    step_n = '0;
    idx_n  = '0;
    if (in_kind_q == KIND_TICK) begin
      if (st_q.step_count >= STEP_LAST) begin
        step_n           = '0;
        st_d.red_latch   = 1'b1;
        st_d.motor_latch = 1'b1;
      end else begin
        step_n = st_q.step_count + 1'b1;
      end
      st_d.step_count = step_n;
      if (step_n >= cfg_i.red_duty)   st_d.red_latch   = 1'b0;
      if (step_n >= st_q.motor_level) st_d.motor_latch = 1'b0;
      if (st_q.lockout_count != '0) begin
        st_d.lockout_count = in_btn_q ? cfg_i.lockout_ticks : st_q.lockout_count - 1'b1;
      end
      st_d.white_latch = in_btn_q;
    end else if (st_q.lockout_count == '0) begin
      idx_n              = (st_q.level_index >= LEVEL_LAST) ? '0 : st_q.level_index + 1'b1;
      st_d.level_index   = idx_n;
      st_d.motor_level   = level_value(idx_n);
      st_d.lockout_count = cfg_i.lockout_ticks;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      if (in_take)   in_vld_q <= 1'b1;
      else if (fire) in_vld_q <= 1'b0;
      if (fire)              out_vld_q <= 1'b1;
      else if (out_o.ready)  out_vld_q <= 1'b0;
      if (fire) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q <= kind_e'(in_i.kind);
      in_btn_q  <= in_i.button_level;
    end
    if (fire) begin
      red_q   <= st_d.red_latch;
      white_q <= st_d.white_latch;
      motor_q <= st_d.motor_latch;
      duty_q  <= st_d.motor_level;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.red_on     = red_q;
  assign out_o.white_on   = white_q;
  assign out_o.motor_on   = motor_q;
  assign out_o.motor_duty = duty_q;

  `PMLD_ASSERT_NOW(a_idx_range, 1'b1, st_q.level_index <= LEVEL_LAST,
    "level index out of range")
  `PMLD_ASSERT_NOW(a_level_matches_idx, 1'b1,
    st_q.motor_level == level_value(st_q.level_index), "motor level off table")
  `PMLD_ASSERT_NOW(a_step_range, 1'b1, st_q.step_count <= STEP_LAST,
    "step counter past wrap")
  `PMLD_ASSERT_NEXT(a_lockout_count_down,
    fire && in_kind_q == KIND_TICK && !in_btn_q && st_q.lockout_count != '0,
    st_q.lockout_count == $past(st_q.lockout_count) - 1'b1, "lockout did not count down")
  `PMLD_ASSERT_NEXT(a_edge_in_lockout,
    fire && in_kind_q == KIND_EDGE && st_q.lockout_count != '0,
    $stable(st_q.motor_level) && $stable(st_q.level_index), "edge taken during lockout")

endmodule
